// File: src/mcst_pkg.sv
// Shared types and constants for the multi-channel timer bank.
// Used by mcst_ctrl, mcst_dp and multi_channel_software_timer_bank.
`default_nettype none

package mcst_pkg;

  localparam int NUM_TIMERS_DEF  = 8;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int OPCODE_W        = 3;
  localparam int INDEX_W         = 3;
  localparam int PERIOD_W        = 32;
  localparam int MASK_W          = 8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK   = 3'd0,
    OP_CREATE = 3'd1,
    OP_START  = 3'd2,
    OP_STOP   = 3'd3,
    OP_CHANGE = 3'd4,
    OP_DELETE = 3'd5,
    OP_QUERY  = 3'd6
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// File: src/mcst_ctrl.sv
// Command sequencer for the timer bank: accepts a transfer, runs an
// execute state in the datapath and strobes the result. Uses mcst_pkg.
`default_nettype none

module mcst_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  output logic                   done,
  output mcst_pkg::ctrl_cmd_t    cmd
);
  import mcst_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.exec;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_EXEC;
      end
      ST_EXEC: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy        = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    case (state)
      ST_IDLE: cmd.capture = start;
      ST_EXEC: begin
        busy     = 1'b1;
        cmd.exec = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_to_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted transfer did not enter execute");
  a_exec_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy) else $error("execute lasted more than one cycle");
  a_exec_to_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done) else $error("execute not followed by result strobe");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result strobe while busy");
`endif

endmodule

`default_nettype wire

// File: src/mcst_dp.sv
// Timer bank datapath: command registers, per-slot stores and down-counter
// lanes, result registers. Driven by mcst_ctrl; uses mcst_pkg.
`default_nettype none

module mcst_dp #(
  parameter int NUM_TIMERS  = mcst_pkg::NUM_TIMERS_DEF,
  parameter int COUNT_WIDTH = mcst_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mcst_pkg::ctrl_cmd_t           cmd,
  input  wire logic [mcst_pkg::OPCODE_W-1:0] opcode,
  input  wire logic [mcst_pkg::INDEX_W-1:0]  timer_index,
  input  wire logic [mcst_pkg::PERIOD_W-1:0] period,
  input  wire logic                          periodic,
  output logic                               status,
  output logic [mcst_pkg::MASK_W-1:0]        expired_mask,
  output logic                               slot_running
);
  import mcst_pkg::*;

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  logic [OPCODE_W-1:0]    op_q;
  logic [IDX_W-1:0]       slot_q;
  logic                   in_bank_q;
  logic [COUNT_WIDTH-1:0] per_q;
  logic                   periodic_q;

  logic [COUNT_WIDTH-1:0] period_store    [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] remaining_store [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]  periodic_flags;
  logic [NUM_TIMERS-1:0]  running_flags;
  logic [NUM_TIMERS-1:0]  created_flags;

  logic [COUNT_WIDTH-1:0] rem_dec [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]  lane_hit;
  logic                   exists;
  logic                   per_zero;

  logic                   status_next;
  logic [MASK_W-1:0]      expired_mask_next;
  logic                   slot_running_next;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q       <= opcode;
      slot_q     <= IDX_W'(timer_index);
      in_bank_q  <= (32'(timer_index) < NUM_TIMERS);
      per_q      <= COUNT_WIDTH'(period);
      periodic_q <= periodic;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      rem_dec[i]  = (remaining_store[i] != '0) ? remaining_store[i] - 1'b1 : '0;
      lane_hit[i] = running_flags[i] && (rem_dec[i] == '0);
    end
  end

  assign exists   = in_bank_q && created_flags[slot_q];
  assign per_zero = (per_q == '0);

  always_comb begin
    status_next       = 1'b0;
    expired_mask_next = '0;
    slot_running_next = 1'b0;
    case (op_q)
      OP_TICK:   expired_mask_next = MASK_W'(lane_hit);
      OP_CREATE: status_next = !in_bank_q || per_zero;
      OP_START, OP_STOP, OP_DELETE: status_next = !exists;
      OP_CHANGE: status_next = !exists || per_zero;
      OP_QUERY: begin
        status_next       = !exists;
        slot_running_next = exists && running_flags[slot_q];
      end
      default: status_next = 1'b1;
    endcase
  end

  // flags
  always_ff @(posedge clk) begin
    if (rst) begin
      running_flags <= '0;
      created_flags <= '0;
    end else if (cmd.exec) begin
      case (op_q)
        OP_TICK: begin
          for (int i = 0; i < NUM_TIMERS; i++) begin
            if (lane_hit[i] && !periodic_flags[i]) running_flags[i] <= 1'b0;
          end
        end
        OP_CREATE: begin
          if (in_bank_q && !per_zero) begin
            running_flags[slot_q] <= 1'b0;
            created_flags[slot_q] <= 1'b1;
          end
        end
        OP_START: begin
          if (exists) running_flags[slot_q] <= 1'b1;
        end
        OP_STOP: begin
          if (exists) running_flags[slot_q] <= 1'b0;
        end
        OP_CHANGE: begin
          if (exists && !per_zero) running_flags[slot_q] <= 1'b1;
        end
        OP_DELETE: begin
          if (exists) begin
            running_flags[slot_q] <= 1'b0;
            created_flags[slot_q] <= 1'b0;
          end
        end
        default: running_flags <= running_flags;
      endcase
    end
  end

  // stores and results
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status       <= status_next;
      expired_mask <= expired_mask_next;
      slot_running <= slot_running_next;
      case (op_q)
        OP_TICK: begin
          for (int i = 0; i < NUM_TIMERS; i++) begin
            if (running_flags[i]) begin
              if (lane_hit[i] && periodic_flags[i]) remaining_store[i] <= period_store[i];
              else remaining_store[i] <= rem_dec[i];
            end
          end
        end
        OP_CREATE: begin
          if (in_bank_q && !per_zero) begin
            period_store[slot_q]    <= per_q;
            remaining_store[slot_q] <= per_q;
            periodic_flags[slot_q]  <= periodic_q;
          end
        end
        OP_START: begin
          if (exists) remaining_store[slot_q] <= period_store[slot_q];
        end
        OP_CHANGE: begin
          if (exists && !per_zero) begin
            period_store[slot_q]    <= per_q;
            remaining_store[slot_q] <= per_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/multi_channel_software_timer_bank.sv
// Top level of the multi-channel timer bank.
// Joins mcst_ctrl (sequencer) and mcst_dp (stores, counter lanes); uses mcst_pkg.
//
// Usage:
//   Drive opcode, timer_index, period and periodic with start high; the
//   command transfer happens at the rising edge where start is high and busy
//   is low. Opcodes: tick, create, start, stop, change period, delete, query.
//   Exactly one result follows each command: done is high for one cycle with
//   status, expired_mask and slot_running valid in that cycle.
// Timing:
//   The command executes in the cycle after the transfer (busy high) and the
//   result strobe comes in the cycle after that. No new command is taken
//   while the sequencer is in its execute state (busy high); on a tick the
//   counters of all running slots update in parallel in that execute state.
// Reset:
//   rst clears the created and running flags of every slot and returns the
//   sequencer to idle; no result is pending afterwards.
// Results are never held off: the receiver must take each one as strobed.
`default_nettype none

module multi_channel_software_timer_bank #(
  parameter int NUM_TIMERS  = mcst_pkg::NUM_TIMERS_DEF,
  parameter int COUNT_WIDTH = mcst_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [mcst_pkg::OPCODE_W-1:0] opcode,
  input  wire logic [mcst_pkg::INDEX_W-1:0]  timer_index,
  input  wire logic [mcst_pkg::PERIOD_W-1:0] period,
  input  wire logic                          periodic,
  output logic                               done,
  output logic                               status,
  output logic [mcst_pkg::MASK_W-1:0]        expired_mask,
  output logic                               slot_running
);
  import mcst_pkg::*;

  ctrl_cmd_t cmd;

  mcst_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  mcst_dp #(
    .NUM_TIMERS  (NUM_TIMERS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .opcode       (opcode),
    .timer_index  (timer_index),
    .period       (period),
    .periodic     (periodic),
    .status       (status),
    .expired_mask (expired_mask),
    .slot_running (slot_running)
  );

endmodule

`default_nettype wire
